@@ rtl/cam_pkg.sv @@
// Package for the circular alpha mask core: widths, constants and shared types.
// No dependencies; every other file of the block imports it.
package cam_pkg;

  localparam int unsigned MaxSide    = 4096;
  localparam int unsigned FracBits   = 8;

  localparam int unsigned CfgW       = 13;
  localparam int unsigned PosW       = 12;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned AbsW       = 13;  // |2*pos + 1 - side| <= 8191
  localparam int unsigned SqW        = 27;  // dx^2 + dy^2
  localparam int unsigned RadSqW     = 26;  // r2^2, r2 <= 4096
  localparam int unsigned InsideSqW  = 25;  // sq when inside the circle, <= 2^24
  localparam int unsigned OperandW   = 42;  // (sq << 2*FracBits) padded to even width
  localparam int unsigned RootW      = 21;  // sqrt result, <= 2^20
  localparam int unsigned RemW       = 23;
  localparam int unsigned SqrtSteps  = OperandW / 2;
  localparam int unsigned DiffW      = 10;  // ramp distance in band, <= 3 << FracBits
  localparam int unsigned RecipW     = 19;
  localparam int unsigned ProdW      = DiffW + RecipW;
  localparam int unsigned RampW      = 17;  // ramp before saturation, <= 65536
  localparam int unsigned TW         = 16;

  // floor(x / 3) == (x * RecipThird) >> 20 for x < 2^19; x = diff << 8
  localparam logic [RecipW-1:0] RecipThird = 19'd349526;
  localparam int unsigned       RecipShift = 20 - FracBits;

  localparam logic [CfgW-1:0] SideReset = 13'd64;
  localparam logic [CfgW-1:0] SideMax   = 13'(MaxSide);

  // accept edge to result cycle: 3 front stages, the root chain, 3 back stages
  localparam int unsigned Latency = 3 + SqrtSteps + 3;

  typedef enum logic [0:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cam_reg_e;

  typedef struct packed {
    logic [PosW-1:0]  column;
    logic [PosW-1:0]  row;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
  } cam_pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } cam_pixel_out_t;

  // saturated geometry derived from the config registers
  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
    logic [CfgW-1:0] radius2;
  } cam_geom_t;

  // pixel data and mask decision riding along the pipeline
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             outside;
    logic             band;
  } cam_side_t;

  // state of the digit-by-digit square root handed from cell to cell
  typedef struct packed {
    logic [OperandW-1:0] operand;
    logic [RootW-1:0]    root;
    logic [RemW-1:0]     rem;
  } cam_sqrt_t;

endpackage

@@ rtl/cam_geom.sv @@
// Front end: doubled offsets, squared distance and circle/band tests (3 stages).
// Depends on cam_pkg.
module cam_geom import cam_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cam_pixel_in_t pixel_i,
  input  cam_geom_t     geom_i,
  output logic          valid_o,
  output cam_sqrt_t     step_o,
  output cam_side_t     side_o
);

  logic [2:0]  valid_q;

  // stage 1: absolute doubled offsets
  logic [AbsW+1:0] dx, dy;
  logic [AbsW-1:0] ax_d, ay_d, ax_q, ay_q;
  cam_side_t       side1_d, side1_q;

  // stage 2: squares
  logic [2*AbsW-1:0] axsq_q, aysq_q;
  logic [RadSqW-1:0] r2sq_q, r2m3sq_q;
  logic [CfgW-1:0]   r2m3;
  cam_side_t         side2_q;

  // stage 3: compares
  logic [SqW-1:0]       sq;
  logic                 outside, band;
  logic [InsideSqW-1:0] sq_in;
  cam_sqrt_t            step_q;
  cam_side_t            side3_d, side3_q;

  always_comb begin
    dx   = {2'b00, pixel_i.column, 1'b1} - {2'b00, geom_i.width};
    dy   = {2'b00, pixel_i.row, 1'b1} - {2'b00, geom_i.height};
    ax_d = dx[AbsW+1] ? AbsW'(-dx) : dx[AbsW-1:0];
    ay_d = dy[AbsW+1] ? AbsW'(-dy) : dy[AbsW-1:0];
    side1_d         = '0;
    side1_d.red     = pixel_i.red_in;
    side1_d.green   = pixel_i.green_in;
    side1_d.blue    = pixel_i.blue_in;
    side1_d.alpha   = pixel_i.alpha_in;
  end

  assign r2m3 = geom_i.radius2 - CfgW'(3);

  always_comb begin
    sq      = SqW'(axsq_q) + SqW'(aysq_q);
    outside = sq > SqW'(r2sq_q);
    band    = !outside && ((geom_i.radius2 < CfgW'(3)) || (sq > SqW'(r2m3sq_q)));
    sq_in   = outside ? '0 : sq[InsideSqW-1:0];
    side3_d         = side2_q;
    side3_d.outside = outside;
    side3_d.band    = band;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    side1_q  <= side1_d;
    axsq_q   <= (2*AbsW)'(ax_q) * (2*AbsW)'(ax_q);
    aysq_q   <= (2*AbsW)'(ay_q) * (2*AbsW)'(ay_q);
    r2sq_q   <= RadSqW'(geom_i.radius2) * RadSqW'(geom_i.radius2);
    r2m3sq_q <= RadSqW'(r2m3) * RadSqW'(r2m3);
    side2_q  <= side1_q;
    step_q.operand   <= {1'b0, sq_in, {(2*FracBits){1'b0}}};
    step_q.root      <= '0;
    step_q.rem       <= '0;
    side3_q          <= side3_d;
  end

  assign valid_o = valid_q[2];
  assign step_o  = step_q;
  assign side_o  = side3_q;

endmodule

@@ rtl/cam_sqrt_cell.sv @@
// One cell of the square root chain: takes two operand bits, yields one root bit.
// Depends on cam_pkg.
module cam_sqrt_cell import cam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cam_sqrt_t step_i,
  input  cam_side_t side_i,
  output logic      valid_o,
  output cam_sqrt_t step_o,
  output cam_side_t side_o
);

  logic [RemW+1:0] rem_ext, trial, rem_sub;
  logic            take;
  logic            valid_q;
  cam_sqrt_t       step_d, step_q;
  cam_side_t       side_q;

  always_comb begin
    rem_ext = {step_i.rem, step_i.operand[OperandW-1 -: 2]};
    trial   = {{(RemW-RootW){1'b0}}, step_i.root, 2'b01};
    take    = rem_ext >= trial;
    rem_sub = rem_ext - trial;
    step_d.rem     = take ? rem_sub[RemW-1:0] : rem_ext[RemW-1:0];
    step_d.root    = {step_i.root[RootW-2:0], take};
    step_d.operand = {step_i.operand[OperandW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;
  assign side_o  = side_q;

endmodule

@@ rtl/cam_ramp.sv @@
// Back end: edge ramp from the root, alpha scaling and output register (3 stages).
// Depends on cam_pkg.
module cam_ramp import cam_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [RootW-1:0] root_i,
  input  cam_side_t       side_i,
  input  logic [CfgW-1:0] radius2_i,
  output logic            done_o,
  output cam_pixel_out_t  result_o
);

  logic [RootW-1:0]     rim_dist;
  logic [DiffW-1:0]     diff_q;
  cam_side_t            side1_q, side2_q;
  logic [ProdW-1:0]     prod;
  logic [RampW-1:0]     ramp_q;
  logic [TW-1:0]        t;
  logic [ChanW+TW-1:0]  scaled;
  logic [ChanW-1:0]     alpha_d;
  logic [1:0]           valid_q;
  logic                 done_q;
  cam_pixel_out_t       result_q;

  // in the band the distance to the rim never exceeds 1.5 pixels (3 << FracBits)
  assign rim_dist = {radius2_i, {FracBits{1'b0}}} - root_i;
  assign prod     = ProdW'(diff_q) * ProdW'(RecipThird);

  always_comb begin
    t      = ramp_q[RampW-1] ? {TW{1'b1}} : ramp_q[TW-1:0];
    scaled = (ChanW+TW)'(side2_q.alpha) * (ChanW+TW)'(t);
    if (side2_q.outside) begin
      alpha_d = '0;
    end else if (side2_q.band) begin
      alpha_d = scaled[ChanW+TW-1:TW];
    end else begin
      alpha_d = side2_q.alpha;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
      done_q  <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q             <= rim_dist[DiffW-1:0];
    side1_q            <= side_i;
    ramp_q             <= prod[RecipShift +: RampW];
    side2_q            <= side1_q;
    result_q.red_out   <= side2_q.red;
    result_q.green_out <= side2_q.green;
    result_q.blue_out  <= side2_q.blue;
    result_q.alpha_out <= alpha_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/circle_alpha_mask_core.sv @@
// Circular alpha mask core: top level with config registers and the root chain.
// Depends on cam_pkg, cam_geom, cam_sqrt_cell and cam_ramp.
//
// Usage:
//   Pixel channel: a pixel (column, row, RGBA) transfers on a rising edge with
//   start high and busy low. busy is always low, so a pixel can be sent on
//   every clock; the core masks one pixel per cycle.
//   Result channel: done_o is high for exactly one cycle with the masked pixel
//   on result_o. The receiver cannot stall; results leave in input order.
//   Pipeline: a pixel passes 3 geometry stages, 21 root cells and 3 ramp
//   stages in turn, and its result transfers while done_o is high. The depth
//   is set by the square root chain: one result bit per cell, 21 bits.
//   Config channel: cfg_valid_i/cfg_ready_o transfer one register (index 0 is
//   image_width, 1 is image_height, 13 bits each). ready is always high. Write
//   only while no pixel is in flight; sides above 4096 are clamped to 4096.
//   Reset: asynchronous, active low; empties the pipeline and sets both sides
//   to 64. No clearing pass is needed.
module circle_alpha_mask_core import cam_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cam_pixel_in_t  pixel_i,
  output logic           done_o,
  output cam_pixel_out_t result_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] width_q, height_q;
  cam_geom_t       geom;
  logic            in_xfer;

  logic      valid_chain [SqrtSteps+1];
  cam_sqrt_t step_chain  [SqrtSteps+1];
  cam_side_t side_chain  [SqrtSteps+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = start && !busy;

  // config registers, decoded by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideReset;
      height_q <= SideReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cam_reg_e'(cfg_index_i))
        RegImageWidth:  width_q  <= cfg_data_i;
        RegImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // user must change config only while idle, unenforced; sides used as clamped
  always_comb begin
    geom.width   = (width_q > SideMax) ? SideMax : width_q;
    geom.height  = (height_q > SideMax) ? SideMax : height_q;
    geom.radius2 = (geom.width < geom.height) ? geom.width : geom.height;
  end

  cam_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .pixel_i (pixel_i),
    .geom_i  (geom),
    .valid_o (valid_chain[0]),
    .step_o  (step_chain[0]),
    .side_o  (side_chain[0])
  );

  // root chain: each cell resolves one bit of floor(sqrt(sq << 16))
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_cell
    cam_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[i]),
      .step_i  (step_chain[i]),
      .side_i  (side_chain[i]),
      .valid_o (valid_chain[i+1]),
      .step_o  (step_chain[i+1]),
      .side_o  (side_chain[i+1])
    );
  end

  cam_ramp u_ramp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_chain[SqrtSteps]),
    .root_i    (step_chain[SqrtSteps].root),
    .side_i    (side_chain[SqrtSteps]),
    .radius2_i (geom.radius2),
    .done_o    (done_o),
    .result_o  (result_o)
  );

`ifndef SYNTHESIS
  // every accepted pixel yields exactly one result, and no result comes without one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && !busy && rst_ni, Latency))
    else $error("result strobe does not match accepted pixels");

  // the red and blue channels pass through the whole pipeline untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.red_out == $past(pixel_i.red_in, Latency)) &&
               (result_o.blue_out == $past(pixel_i.blue_in, Latency)))
    else $error("colour channel altered");

  // the mask only ever lowers opacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.alpha_out <= $past(pixel_i.alpha_in, Latency))
    else $error("alpha raised by mask");
`endif

endmodule
